// File: design/msdf_pkg.sv
// Shared types and constants of the multi-sensor detection fuser.
// No dependencies; imported by every design module except msdf_ram.
`default_nettype none

package msdf_pkg;

    // Table size and derived widths
    localparam int MAX_FUSED = 256;
    localparam int ADDR_W    = $clog2(MAX_FUSED);
    localparam int CNT_W     = ADDR_W + 1;

    // Field widths
    localparam int QW    = 16;      // quaternion / rotation element, Q1.14
    localparam int PW    = 32;      // position, Q16.16
    localparam int CW    = 21;      // covariance element, Q8.12
    localparam int RW    = 3 * CW;  // packed covariance row
    localparam int THR_W = 25;
    localparam int IDI_W = 16;
    localparam int ID_W  = 32;
    localparam int ENT_W = 3 * PW;  // stored table entry {z, y, x}

    localparam int ONE_Q14 = 16384;

    typedef logic [8:0][QW-1:0] t_rmat;
    typedef logic [2:0][PW-1:0] t_vec;
    typedef logic [2:0][RW-1:0] t_rows;

    typedef enum logic [1:0] {
        REQ_CYCLE  = 2'd0,
        REQ_SENSOR = 2'd1,
        REQ_DETECT = 2'd2,
        REQ_NOP    = 2'd3
    } t_req;

    // Result status codes
    localparam logic [2:0] ST_ACCEPT   = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_INVALID  = 3'd2;
    localparam logic [2:0] ST_CTRL     = 3'd3;
    localparam logic [2:0] ST_UNSTORED = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_THR    = 2'd0;
    localparam logic [1:0] CFG_ID_INC = 2'd1;
    localparam logic [1:0] CFG_ID_OFF = 2'd2;

    // Rotation loader write into the matrix registers
    typedef struct packed {
        logic          we;
        logic [3:0]    idx;
        logic [QW-1:0] val;
        logic          done;
    } t_rot_wr;

    // Table store request from the control FSM
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
    } t_store;

    // Duplicate scan outcome
    typedef struct packed {
        logic              done;
        logic              hit;
        logic [ADDR_W-1:0] idx;
    } t_scan_res;

    // Row-major index of a 3x3 element
    function automatic logic [3:0] midx(input logic [1:0] r, input logic [1:0] c);
        return 4'({2'b00, r} * 4'd3 + {2'b00, c});
    endfunction

endpackage

`default_nettype wire

// File: design/multi_sensor_detection_fuser_unit.sv
// Top level of the multi-sensor detection fuser: request control, config
// registers, IDs. Depends on msdf_pkg, msdf_rot, msdf_xform, msdf_scan.
`default_nettype none

// One request at a time: a request is taken when i_start is high and o_busy
// is low, and gives exactly one result, shown for one cycle with o_valid.
// The receiver cannot stall, so results must be consumed as they appear.
// Cycle-start and no-op requests, and detections flagged invalid, answer
// straight from idle. A sensor start runs 10 multiplier steps, then a
// 16-step divider for each of the nine rotation elements; a zero quaternion
// skips the divider. A detection runs 63 MAC steps for the transform, then a
// scan of the entries stored before the last sensor start, reading one table
// entry per cycle through a pipelined compare and stopping on a hit. The
// table needs no clearing pass after reset. Configuration must be written
// by the user only while idle; the block itself does not enforce it.
module multi_sensor_detection_fuser_unit import msdf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [1:0]           i_req_type,
    input  logic signed [QW-1:0] i_quat_x,
    input  logic signed [QW-1:0] i_quat_y,
    input  logic signed [QW-1:0] i_quat_z,
    input  logic signed [QW-1:0] i_quat_w,
    input  logic signed [PW-1:0] i_pos_x,
    input  logic signed [PW-1:0] i_pos_y,
    input  logic signed [PW-1:0] i_pos_z,
    input  logic [RW-1:0]        i_cov_row0,
    input  logic [RW-1:0]        i_cov_row1,
    input  logic [RW-1:0]        i_cov_row2,
    input  logic                 i_pos_invalid,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [ID_W-1:0]      i_cfg_data,
    output logic                 o_valid,
    output logic [2:0]           o_status,
    output logic [ID_W-1:0]      o_fused_id,
    output logic signed [PW-1:0] o_world_x,
    output logic signed [PW-1:0] o_world_y,
    output logic signed [PW-1:0] o_world_z,
    output logic [RW-1:0]        o_world_cov_row0,
    output logic [RW-1:0]        o_world_cov_row1,
    output logic [RW-1:0]        o_world_cov_row2,
    output logic [7:0]           o_match_index
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ROT  = 4'b0010,
        S_XF   = 4'b0100,
        S_SCAN = 4'b1000
    } t_state;

    t_state r_st, n_st;
    logic [THR_W-1:0]   r_thr;
    logic [2*THR_W-1:0] r_thr_sq;
    logic [IDI_W-1:0]   r_inc;
    logic [ID_W-1:0]    r_next_id, n_next_id;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_limit, n_limit;
    t_rmat              r_rmat;
    t_vec               r_trans;

    logic               r_valid, n_valid;
    logic [2:0]         r_status, n_status;
    logic [ID_W-1:0]    r_id, n_id;
    t_vec               r_wpos, n_wpos;
    t_rows              r_wcov, n_wcov;
    logic [7:0]         r_midx, n_midx;

    logic      w_accept;
    logic      w_rot_start, w_xf_start, w_scan_start;
    t_rot_wr   w_rot;
    logic      w_xf_done;
    t_vec      w_pos, w_xf_pos;
    t_rows     w_cov, w_xf_cov;
    t_store    w_store;
    t_scan_res w_res;

    assign w_accept    = i_start && !o_busy;
    assign o_busy      = (r_st != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_pos       = {i_pos_z, i_pos_y, i_pos_x};
    assign w_cov       = {i_cov_row2, i_cov_row1, i_cov_row0};

    msdf_rot u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_rot_start),
        .i_qx    (i_quat_x),
        .i_qy    (i_quat_y),
        .i_qz    (i_quat_z),
        .i_qw    (i_quat_w),
        .o_wr    (w_rot)
    );

    msdf_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_xf_start),
        .i_rmat  (r_rmat),
        .i_trans (r_trans),
        .i_pos   (w_pos),
        .i_cov   (w_cov),
        .o_done  (w_xf_done),
        .o_wpos  (w_xf_pos),
        .o_wcov  (w_xf_cov)
    );

    msdf_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_scan_start),
        .i_limit  (r_limit),
        .i_wpos   (w_xf_pos),
        .i_thr    (r_thr),
        .i_thr_sq (r_thr_sq),
        .i_store  (w_store),
        .o_res    (w_res)
    );

    // Request sequencing and result formation
    always_comb begin
        n_st         = r_st;
        n_count      = r_count;
        n_limit      = r_limit;
        n_next_id    = r_next_id;
        n_valid      = 1'b0;
        n_status     = ST_CTRL;
        n_id         = '0;
        n_wpos       = '0;
        n_wcov       = '0;
        n_midx       = '0;
        w_rot_start  = 1'b0;
        w_xf_start   = 1'b0;
        w_scan_start = 1'b0;
        w_store      = '0;
        case (r_st)
            S_IDLE: begin
                if (w_accept) begin
                    case (t_req'(i_req_type))
                        REQ_CYCLE: begin
                            n_count = '0;
                            n_limit = '0;
                            n_valid = 1'b1;
                        end
                        REQ_SENSOR: begin
                            w_rot_start = 1'b1;
                            n_limit     = r_count;
                            n_st        = S_ROT;
                        end
                        REQ_DETECT: begin
                            if (i_pos_invalid) begin
                                n_valid  = 1'b1;
                                n_status = ST_INVALID;
                            end else begin
                                w_xf_start = 1'b1;
                                n_st       = S_XF;
                            end
                        end
                        default: n_valid = 1'b1;
                    endcase
                end
            end
            S_ROT: begin
                if (w_rot.done) begin
                    n_valid = 1'b1;
                    n_st    = S_IDLE;
                end
            end
            S_XF: begin
                if (w_xf_done) begin
                    w_scan_start = 1'b1;
                    n_st         = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_res.done) begin
                    n_valid = 1'b1;
                    n_wpos  = w_xf_pos;
                    n_wcov  = w_xf_cov;
                    n_st    = S_IDLE;
                    if (w_res.hit) begin
                        n_status = ST_DUP;
                        n_midx   = 8'(w_res.idx);
                    end else begin
                        n_id      = r_next_id;
                        n_next_id = r_next_id + ID_W'(r_inc);
                        if (r_count < CNT_W'(MAX_FUSED)) begin
                            w_store.we   = 1'b1;
                            w_store.addr = r_count[ADDR_W-1:0];
                            n_count      = r_count + CNT_W'(1);
                            n_status     = ST_ACCEPT;
                        end else begin
                            n_status = ST_UNSTORED;
                        end
                    end
                end
            end
            default: n_st = S_IDLE;
        endcase
        // ID offset write reloads the counter
        if (i_cfg_valid && i_cfg_index == CFG_ID_OFF) begin
            n_next_id = i_cfg_data;
        end
    end

    // Control and configuration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_IDLE;
            r_thr     <= THR_W'(32768);
            r_inc     <= IDI_W'(1);
            r_next_id <= '0;
            r_count   <= '0;
            r_limit   <= '0;
            r_rmat    <= '0;
            r_trans   <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_st      <= n_st;
            r_next_id <= n_next_id;
            r_count   <= n_count;
            r_limit   <= n_limit;
            r_valid   <= n_valid;
            if (w_rot.we) begin
                r_rmat[w_rot.idx] <= w_rot.val;
            end
            if (w_rot_start) begin
                r_trans <= w_pos;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_THR:    r_thr <= i_cfg_data[THR_W-1:0];
                    CFG_ID_INC: r_inc <= i_cfg_data[IDI_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    // Result payload and squared threshold
    always_ff @(posedge i_clk) begin
        r_thr_sq <= r_thr * r_thr;
        r_status <= n_status;
        r_id     <= n_id;
        r_wpos   <= n_wpos;
        r_wcov   <= n_wcov;
        r_midx   <= n_midx;
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_fused_id       = r_id;
    assign o_world_x        = r_wpos[0];
    assign o_world_y        = r_wpos[1];
    assign o_world_z        = r_wpos[2];
    assign o_world_cov_row0 = r_wcov[0];
    assign o_world_cov_row1 = r_wcov[1];
    assign o_world_cov_row2 = r_wcov[2];
    assign o_match_index    = r_midx;

endmodule

`default_nettype wire

// File: design/msdf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module msdf_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: design/msdf_rot.sv
// Quaternion to rotation matrix loader: shared 16x16 multiplier for the
// products, then a radix-2 divider per element. Depends on msdf_pkg.
`default_nettype none

module msdf_rot import msdf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [QW-1:0] i_qx,
    input  logic signed [QW-1:0] i_qy,
    input  logic signed [QW-1:0] i_qz,
    input  logic signed [QW-1:0] i_qw,
    output t_rot_wr              o_wr
);

    typedef enum logic [3:0] {
        R_IDLE = 4'b0001,
        R_MUL  = 4'b0010,
        R_NUM  = 4'b0100,
        R_DIV  = 4'b1000
    } t_rstate;

    t_rstate r_st;
    logic signed [QW-1:0] r_q [4];     // x y z w
    logic signed [31:0]   r_prod [10]; // xx yy zz ww xy zw xz yw yz xw
    logic [3:0]           r_cnt;       // product step, then element index
    logic [3:0]           r_bit;
    logic [34:0]          r_rem;
    logic [15:0]          r_lo;
    logic [15:0]          r_quo;
    logic                 r_neg;

    logic signed [QW-1:0] w_ma, w_mb;
    logic signed [31:0]   w_mul;
    logic signed [35:0]   w_d, w_n, w_mag;
    logic signed [35:0]   w_p [10];
    logic                 w_ident;
    logic [49:0]          w_num;
    logic [34:0]          w_den;
    logic [35:0]          w_sh, w_sub;
    logic                 w_ge;
    logic [15:0]          w_qn;
    logic                 w_last_div;

    // Product operand select
    always_comb begin
        case (r_cnt)
            4'd0:    begin w_ma = r_q[0]; w_mb = r_q[0]; end
            4'd1:    begin w_ma = r_q[1]; w_mb = r_q[1]; end
            4'd2:    begin w_ma = r_q[2]; w_mb = r_q[2]; end
            4'd3:    begin w_ma = r_q[3]; w_mb = r_q[3]; end
            4'd4:    begin w_ma = r_q[0]; w_mb = r_q[1]; end
            4'd5:    begin w_ma = r_q[2]; w_mb = r_q[3]; end
            4'd6:    begin w_ma = r_q[0]; w_mb = r_q[2]; end
            4'd7:    begin w_ma = r_q[1]; w_mb = r_q[3]; end
            4'd8:    begin w_ma = r_q[1]; w_mb = r_q[2]; end
            4'd9:    begin w_ma = r_q[0]; w_mb = r_q[3]; end
            default: begin w_ma = r_q[0]; w_mb = r_q[0]; end
        endcase
        w_mul = w_ma * w_mb;
    end

    // Norm and numerator of the current element
    always_comb begin
        for (int i = 0; i < 10; i++) begin
            w_p[i] = 36'(r_prod[i]);
        end
        w_d = w_p[0] + w_p[1] + w_p[2] + w_p[3];
        case (r_cnt)
            4'd0:    w_n = w_d - ((w_p[1] + w_p[2]) <<< 1);
            4'd1:    w_n = (w_p[4] - w_p[5]) <<< 1;
            4'd2:    w_n = (w_p[6] + w_p[7]) <<< 1;
            4'd3:    w_n = (w_p[4] + w_p[5]) <<< 1;
            4'd4:    w_n = w_d - ((w_p[0] + w_p[2]) <<< 1);
            4'd5:    w_n = (w_p[8] - w_p[9]) <<< 1;
            4'd6:    w_n = (w_p[6] - w_p[7]) <<< 1;
            4'd7:    w_n = (w_p[8] + w_p[9]) <<< 1;
            4'd8:    w_n = w_d - ((w_p[0] + w_p[1]) <<< 1);
            default: w_n = '0;
        endcase
        w_ident = (w_d == '0);
        w_mag   = (w_n < 0) ? -w_n : w_n;
        // round half away from zero: (|n| * 2^15 + d) / (2d)
        w_num   = {1'b0, w_mag[33:0], 15'd0} + 50'(w_d[33:0]);
        w_den   = {w_d[33:0], 1'b0};
    end

    // Divider step
    always_comb begin
        w_sh       = {r_rem, r_lo[15]};
        w_ge       = w_sh >= {1'b0, w_den};
        w_sub      = w_sh - {1'b0, w_den};
        w_qn       = {r_quo[14:0], w_ge};
        w_last_div = (r_st == R_DIV) && (r_bit == 4'd15);
    end

    // Matrix element write
    always_comb begin
        o_wr.we  = ((r_st == R_NUM) && w_ident) || w_last_div;
        o_wr.idx = r_cnt;
        if (r_st == R_NUM) begin
            o_wr.val = (r_cnt == 4'd0 || r_cnt == 4'd4 || r_cnt == 4'd8) ?
                       QW'(ONE_Q14) : '0;
        end else begin
            o_wr.val = r_neg ? -w_qn : w_qn;
        end
        o_wr.done = o_wr.we && (r_cnt == 4'd8);
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= R_IDLE;
            r_cnt <= '0;
            r_bit <= '0;
        end else begin
            case (r_st)
                R_IDLE: begin
                    if (i_start) begin
                        r_q[0] <= i_qx;
                        r_q[1] <= i_qy;
                        r_q[2] <= i_qz;
                        r_q[3] <= i_qw;
                        r_cnt  <= '0;
                        r_st   <= R_MUL;
                    end
                end
                R_MUL: begin
                    r_prod[r_cnt] <= w_mul;
                    if (r_cnt == 4'd9) begin
                        r_cnt <= '0;
                        r_st  <= R_NUM;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                R_NUM: begin
                    if (w_ident) begin
                        if (r_cnt == 4'd8) begin
                            r_st <= R_IDLE;
                        end else begin
                            r_cnt <= r_cnt + 4'd1;
                        end
                    end else begin
                        r_rem <= 35'(w_num[49:16]);
                        r_lo  <= w_num[15:0];
                        r_quo <= '0;
                        r_neg <= w_n < 0;
                        r_bit <= '0;
                        r_st  <= R_DIV;
                    end
                end
                R_DIV: begin
                    r_rem <= w_ge ? w_sub[34:0] : w_sh[34:0];
                    r_lo  <= {r_lo[14:0], 1'b0};
                    r_quo <= w_qn;
                    r_bit <= r_bit + 4'd1;
                    if (r_bit == 4'd15) begin
                        if (r_cnt == 4'd8) begin
                            r_st <= R_IDLE;
                        end else begin
                            r_cnt <= r_cnt + 4'd1;
                            r_st  <= R_NUM;
                        end
                    end
                end
                default: r_st <= R_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/msdf_xform.sv
// World-frame transform: R*p+t and R*C*R^T on one shared 16x40 MAC.
// Depends on msdf_pkg.
`default_nettype none

module msdf_xform import msdf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_rmat i_rmat,
    input  t_vec  i_trans,
    input  t_vec  i_pos,
    input  t_rows i_cov,
    output logic  o_done,
    output t_vec  o_wpos,
    output t_rows o_wcov
);

    typedef enum logic [3:0] {
        X_IDLE = 4'b0001,
        X_POS  = 4'b0010,
        X_MID  = 4'b0100,
        X_OUT  = 4'b1000
    } t_xstate;

    t_xstate r_ph;
    t_vec                 r_pos;
    logic signed [CW-1:0] r_c [9];
    logic signed [39:0]   r_m [9];
    logic signed [57:0]   r_acc;
    logic [1:0]           r_o, r_u, r_v;
    t_vec                 r_wpos;
    logic [2:0][2:0][CW-1:0] r_wc;
    logic                 r_done;

    logic [3:0]           w_ridx;
    logic signed [QW-1:0] w_a;
    logic signed [39:0]   w_b;
    logic signed [55:0]   w_prod;
    logic signed [57:0]   w_acc, w_rp, w_sp, w_rc;
    logic                 w_last_v, w_last_u, w_last_o;

    function automatic logic [PW-1:0] sat_pos(input logic signed [57:0] v);
        if (v > 58'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -58'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[PW-1:0];
    endfunction

    function automatic logic [CW-1:0] sat_cov(input logic signed [57:0] v);
        if (v > 58'sd1048575) begin
            return 21'h0F_FFFF;
        end else if (v < -58'sd1048576) begin
            return 21'h10_0000;
        end
        return v[CW-1:0];
    endfunction

    // MAC operands and rounding
    always_comb begin
        w_ridx = (r_ph == X_OUT) ? midx(r_u, r_v) : midx(r_o, r_v);
        w_a    = $signed(i_rmat[w_ridx]);
        case (r_ph)
            X_POS:   w_b = 40'($signed(r_pos[r_v]));
            X_MID:   w_b = 40'(r_c[midx(r_v, r_u)]);
            default: w_b = r_m[midx(r_o, r_v)];
        endcase
        w_prod = w_a * w_b;
        w_acc  = ((r_v == 2'd0) ? 58'sd0 : r_acc) + 58'(w_prod);
        w_rp   = (w_acc + 58'sd8192) >>> 14;
        w_sp   = w_rp + 58'($signed(i_trans[r_o]));
        w_rc   = (w_acc + 58'sd134217728) >>> 28;
        w_last_v = (r_v == 2'd2);
        w_last_u = (r_ph == X_POS) || (r_u == 2'd2);
        w_last_o = (r_o == 2'd2);
    end

    // Loop counters and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= X_IDLE;
            r_o    <= '0;
            r_u    <= '0;
            r_v    <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_ph == X_IDLE) begin
                if (i_start) begin
                    r_pos <= i_pos;
                    for (int i = 0; i < 3; i++) begin
                        for (int j = 0; j < 3; j++) begin
                            r_c[3*i+j] <= $signed(i_cov[i][CW*j +: CW]);
                        end
                    end
                    r_o  <= '0;
                    r_u  <= '0;
                    r_v  <= '0;
                    r_ph <= X_POS;
                end
            end else begin
                r_acc <= w_acc;
                if (w_last_v) begin
                    case (r_ph)
                        X_POS:   r_wpos[r_o] <= sat_pos(w_sp);
                        X_MID:   r_m[midx(r_o, r_u)] <= 40'(w_acc);
                        default: r_wc[r_o][r_u] <= sat_cov(w_rc);
                    endcase
                end
                if (!w_last_v) begin
                    r_v <= r_v + 2'd1;
                end else begin
                    r_v <= '0;
                    if (!w_last_u) begin
                        r_u <= r_u + 2'd1;
                    end else begin
                        r_u <= '0;
                        if (!w_last_o) begin
                            r_o <= r_o + 2'd1;
                        end else begin
                            r_o <= '0;
                            case (r_ph)
                                X_POS: r_ph <= X_MID;
                                X_MID: r_ph <= X_OUT;
                                default: begin
                                    r_ph   <= X_IDLE;
                                    r_done <= 1'b1;
                                end
                            endcase
                        end
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_wpos = r_wpos;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_wcov[i] = r_wc[i];
        end
    end

endmodule

`default_nettype wire

// File: design/msdf_scan.sv
// Accepted-position table and the pipelined duplicate scan over it.
// Depends on msdf_pkg and msdf_ram.
`default_nettype none

module msdf_scan import msdf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [CNT_W-1:0]   i_limit,
    input  t_vec               i_wpos,
    input  logic [THR_W-1:0]   i_thr,
    input  logic [2*THR_W-1:0] i_thr_sq,
    input  t_store             i_store,
    output t_scan_res          o_res
);

    logic              r_act;
    logic [CNT_W-1:0]  r_ai;
    logic              r_v1, r_v2, r_v3;
    logic [ADDR_W-1:0] r_i1, r_i2, r_i3;
    logic [THR_W-1:0]  r_abs2 [3];
    logic              r_ge2, r_ge3;
    logic [2*THR_W-1:0] r_sq3 [3];
    t_scan_res         r_res;

    logic [ENT_W-1:0]  w_rdata;
    t_vec              w_ent;
    logic              w_issue;
    logic signed [PW:0] w_diff [3];
    logic [PW:0]       w_abs [3];
    logic              w_ge;
    logic [2*THR_W+1:0] w_sum;
    logic              w_hit, w_done;

    msdf_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_FUSED)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_store.we),
        .i_waddr (i_store.addr),
        .i_wdata (i_wpos),
        .i_raddr (r_ai[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    // Distance stages
    always_comb begin
        w_ent   = w_rdata;
        w_issue = r_act && (r_ai < i_limit);
        w_ge    = 1'b0;
        for (int k = 0; k < 3; k++) begin
            w_diff[k] = 33'($signed(i_wpos[k])) - 33'($signed(w_ent[k]));
            w_abs[k]  = (w_diff[k] < 0) ? 33'(-w_diff[k]) : 33'(w_diff[k]);
            w_ge      = w_ge || (w_abs[k] >= 33'(i_thr));
        end
        w_sum  = 52'(r_sq3[0]) + 52'(r_sq3[1]) + 52'(r_sq3[2]);
        w_hit  = r_v3 && !r_ge3 && (w_sum < 52'(i_thr_sq));
        w_done = w_hit || (r_act && !w_issue && !r_v1 && !r_v2 && !r_v3);
    end

    // Scan control and pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_ai  <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_res <= '0;
        end else begin
            r_res.done <= r_act && w_done;
            r_res.hit  <= w_hit;
            r_res.idx  <= r_i3;
            if (i_start) begin
                r_act <= 1'b1;
                r_ai  <= '0;
                r_v1  <= 1'b0;
                r_v2  <= 1'b0;
                r_v3  <= 1'b0;
            end else if (r_act && w_done) begin
                r_act <= 1'b0;
                r_v1  <= 1'b0;
                r_v2  <= 1'b0;
                r_v3  <= 1'b0;
            end else begin
                r_v1 <= w_issue;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                if (w_issue) begin
                    r_ai <= r_ai + CNT_W'(1);
                end
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        r_i1  <= r_ai[ADDR_W-1:0];
        r_i2  <= r_i1;
        r_i3  <= r_i2;
        r_ge2 <= w_ge;
        r_ge3 <= r_ge2;
        for (int k = 0; k < 3; k++) begin
            r_abs2[k] <= w_abs[k][THR_W-1:0];
            r_sq3[k]  <= r_abs2[k] * r_abs2[k];
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire
